/* src/wbsv_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Write batch validator package
// Shared types, field widths and parse codes for the write batch validator.
// ----------------------------------------------------------------------------
package wbsv_pkg;

  localparam int SEQ_BITS_DEF = 56;   // default width of the legal sequence range
  localparam int SEQ_OUT_W    = 56;   // width of the reported entry sequence
  localparam int LEN_W        = 32;   // varint32 lengths, counts and indexes
  localparam int ACC_SHIFT_W  = 39;   // seven payload bits shifted by up to 28

  localparam logic [3:0] BASE_BYTES    = 4'd8;   // header bytes of base sequence
  localparam logic [3:0] HDR_LAST_IDX  = 4'd11;  // index of the final header byte
  localparam logic [2:0] VARINT_LAST   = 3'd4;   // index of the fifth length byte
  localparam logic [7:0] VARINT_MASK   = 8'h7f;  // payload bits of a length byte
  localparam int         VARINT_CONT   = 7;      // continuation bit position
  localparam logic [5:0] VARINT_STEP   = 6'd7;   // payload bits per length byte
  localparam logic [7:0] KIND_MAX      = 8'd1;   // highest legal kind byte

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_KIND   = 3'd1,
    PH_KEYLEN = 3'd2,
    PH_KEY    = 3'd3,
    PH_VALLEN = 3'd4,
    PH_VAL    = 3'd5,
    PH_TRAIL  = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_HEADER  = 3'd0,
    ROLE_KIND    = 3'd1,
    ROLE_KEYLEN  = 3'd2,
    ROLE_KEY     = 3'd3,
    ROLE_VALLEN  = 3'd4,
    ROLE_VAL     = 3'd5,
    ROLE_DISCARD = 3'd6
  } role_t;

  typedef enum logic [2:0] {
    ST_RUN    = 3'd0,
    ST_OK     = 3'd1,
    ST_SHORT  = 3'd2,
    ST_RANGE  = 3'd3,
    ST_EXCESS = 3'd4,
    ST_KIND   = 3'd5,
    ST_LEN    = 3'd6,
    ST_TRAIL  = 3'd7
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    role_t                  byte_role;
    logic [SEQ_OUT_W-1:0]   entry_sequence;
    logic                   entry_kind;
    logic                   entry_end;
    status_t                status;
    logic                   batch_done;
  } res_t;

endpackage
`default_nettype wire

/* src/wbsv_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Write batch validator channels
// Byte input channel and per-byte result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface wbsv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbsv_out_if;
  logic                           valid;
  logic                           ready;
  logic [2:0]                     byte_role;
  logic [wbsv_pkg::SEQ_OUT_W-1:0] entry_sequence;
  logic                           entry_kind;
  logic                           entry_end;
  logic [2:0]                     status;
  logic                           batch_done;

  modport source (output valid, output byte_role, output entry_sequence,
                  output entry_kind, output entry_end, output status,
                  output batch_done, input ready);
  modport sink   (input valid, input byte_role, input entry_sequence,
                  input entry_kind, input entry_end, input status,
                  input batch_done, output ready);
endinterface
`default_nettype wire

/* src/wbsv_in_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Write batch validator input stage
// Registers one incoming byte transaction until the parser takes it.
// ----------------------------------------------------------------------------
module wbsv_in_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire wbsv_pkg::item_t in_item,
  input  wire logic            pop,
  output logic                 item_vld,
  output wbsv_pkg::item_t      item
);

  logic            vld_r;
  logic            vld_nxt;
  wbsv_pkg::item_t item_r;

  assign in_ready = !vld_r || pop;
  assign vld_nxt  = (in_valid && in_ready) || (vld_r && !pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // load payload on every accepted transaction
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule
`default_nettype wire

/* src/wbsv_parser.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Write batch validator parser
// Parse state and the per-byte decode of header, kind, lengths and fields.
// ----------------------------------------------------------------------------
module wbsv_parser #(
  parameter int SEQUENCE_BITS = wbsv_pkg::SEQ_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire wbsv_pkg::item_t item,
  output wbsv_pkg::res_t       res
);

  localparam int SUM_W = ((SEQUENCE_BITS > wbsv_pkg::LEN_W) ?
                          SEQUENCE_BITS : wbsv_pkg::LEN_W) + 1;
  localparam int SEQ_W = wbsv_pkg::SEQ_OUT_W;
  localparam int LW    = wbsv_pkg::LEN_W;
  localparam int AW    = wbsv_pkg::ACC_SHIFT_W;

  wbsv_pkg::phase_t        phase_r, phase_nxt;
  wbsv_pkg::status_t       sticky_r, sticky_nxt;
  logic [3:0]              hdr_cnt_r, hdr_cnt_nxt;
  logic [SEQUENCE_BITS-1:0] base_r, base_nxt;
  logic                    base_hi_r, base_hi_nxt;
  logic [LW-1:0]           total_r, total_nxt;
  logic [LW-1:0]           idx_r, idx_nxt;
  logic [LW-1:0]           acc_r, acc_nxt;
  logic [2:0]              vcnt_r, vcnt_nxt;
  logic [LW-1:0]           left_r, left_nxt;
  logic                    kind_r, kind_nxt;

  logic                    end_evt;
  logic                    fin_field;
  logic                    fin_is_key;

  logic [63:0]             hdr_shift;
  logic [SEQUENCE_BITS-1:0] base_ins;
  logic                    base_ins_hi;
  logic [LW-1:0]           total_new;
  logic [SUM_W-1:0]        last_seq;
  logic                    range_ok;
  logic [AW-1:0]           acc_shift;
  logic [LW-1:0]           acc_new;
  logic [LW-1:0]           idx_inc;
  logic [LW-1:0]           left_dec;
  logic                    cont;
  wbsv_pkg::status_t       st_out;

  // header byte placement
  assign hdr_shift   = 64'(item.data_byte) << {hdr_cnt_r[2:0], 3'b000};
  assign base_ins    = hdr_shift[SEQUENCE_BITS-1:0];
  assign base_ins_hi = |(hdr_shift >> SEQUENCE_BITS);
  assign total_new   = total_r | (LW'(item.data_byte) << {hdr_cnt_r[1:0], 3'b000});

  // last sequence of the batch must stay inside the legal range
  assign last_seq = SUM_W'(base_r) + SUM_W'(total_new - LW'(1));
  assign range_ok = !base_hi_r &&
                    ((total_new == '0) || ((last_seq >> SEQUENCE_BITS) == '0));

  // varint accumulation, bits beyond 32 dropped
  assign acc_shift = AW'(item.data_byte & wbsv_pkg::VARINT_MASK)
                     << (6'(vcnt_r) * wbsv_pkg::VARINT_STEP);
  assign acc_new   = acc_r | acc_shift[LW-1:0];
  assign cont      = item.data_byte[wbsv_pkg::VARINT_CONT];

  assign idx_inc    = idx_r + LW'(1);
  assign left_dec   = left_r - LW'(1);
  assign fin_is_key = (phase_r == wbsv_pkg::PH_KEYLEN) || (phase_r == wbsv_pkg::PH_KEY);

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    sticky_nxt  = sticky_r;
    hdr_cnt_nxt = hdr_cnt_r;
    base_nxt    = base_r;
    base_hi_nxt = base_hi_r;
    total_nxt   = total_r;
    idx_nxt     = idx_r;
    acc_nxt     = acc_r;
    vcnt_nxt    = vcnt_r;
    left_nxt    = left_r;
    kind_nxt    = kind_r;
    fin_field   = 1'b0;
    end_evt     = 1'b0;
    if (sticky_r == wbsv_pkg::ST_RUN) begin
      case (phase_r)
        wbsv_pkg::PH_HEADER: begin
          if (hdr_cnt_r < wbsv_pkg::BASE_BYTES) begin
            base_nxt    = base_r | base_ins;
            base_hi_nxt = base_hi_r | base_ins_hi;
          end else begin
            total_nxt = total_new;
          end
          hdr_cnt_nxt = hdr_cnt_r + 4'd1;
          if (hdr_cnt_r == wbsv_pkg::HDR_LAST_IDX) begin
            if (!range_ok) begin
              sticky_nxt = wbsv_pkg::ST_RANGE;
            end else if (total_new == '0) begin
              phase_nxt = wbsv_pkg::PH_TRAIL;
            end else begin
              phase_nxt = wbsv_pkg::PH_KIND;
            end
          end
        end
        wbsv_pkg::PH_KIND: begin
          if (item.data_byte > wbsv_pkg::KIND_MAX) begin
            sticky_nxt = wbsv_pkg::ST_KIND;
          end else begin
            kind_nxt  = item.data_byte[0];
            acc_nxt   = '0;
            vcnt_nxt  = '0;
            phase_nxt = wbsv_pkg::PH_KEYLEN;
          end
        end
        wbsv_pkg::PH_KEYLEN, wbsv_pkg::PH_VALLEN: begin
          acc_nxt = acc_new;
          if (cont) begin
            if (vcnt_r >= wbsv_pkg::VARINT_LAST) begin
              sticky_nxt = wbsv_pkg::ST_LEN;
            end else begin
              vcnt_nxt = vcnt_r + 3'd1;
            end
          end else begin
            left_nxt = acc_new;
            acc_nxt  = '0;
            vcnt_nxt = '0;
            if (acc_new == '0) begin
              fin_field = 1'b1;
            end else if (fin_is_key) begin
              phase_nxt = wbsv_pkg::PH_KEY;
            end else begin
              phase_nxt = wbsv_pkg::PH_VAL;
            end
          end
        end
        wbsv_pkg::PH_KEY, wbsv_pkg::PH_VAL: begin
          left_nxt = left_dec;
          if (left_dec == '0) begin
            fin_field = 1'b1;
          end
        end
        default: begin
          sticky_nxt = wbsv_pkg::ST_TRAIL;
        end
      endcase
      // field complete: value follows for a put key, else the record ends
      if (fin_field) begin
        if (fin_is_key && kind_r) begin
          phase_nxt = wbsv_pkg::PH_VALLEN;
        end else begin
          end_evt   = 1'b1;
          idx_nxt   = idx_inc;
          phase_nxt = (idx_inc == total_r) ? wbsv_pkg::PH_TRAIL : wbsv_pkg::PH_KIND;
        end
      end
    end
  end

  // final status on the last byte
  always_comb begin
    st_out = sticky_nxt;
    if (item.last_byte && (sticky_nxt == wbsv_pkg::ST_RUN)) begin
      case (phase_nxt)
        wbsv_pkg::PH_HEADER: st_out = wbsv_pkg::ST_SHORT;
        wbsv_pkg::PH_KIND:   st_out = wbsv_pkg::ST_EXCESS;
        wbsv_pkg::PH_TRAIL:  st_out = wbsv_pkg::ST_OK;
        default:             st_out = wbsv_pkg::ST_LEN;
      endcase
    end
  end

  // result fields
  always_comb begin
    res.byte_role      = wbsv_pkg::ROLE_DISCARD;
    res.entry_sequence = '0;
    res.entry_kind     = 1'b0;
    res.entry_end      = end_evt;
    res.status         = st_out;
    res.batch_done     = item.last_byte;
    if (sticky_r == wbsv_pkg::ST_RUN) begin
      case (phase_r)
        wbsv_pkg::PH_HEADER: res.byte_role = wbsv_pkg::ROLE_HEADER;
        wbsv_pkg::PH_KIND:   res.byte_role = wbsv_pkg::ROLE_KIND;
        wbsv_pkg::PH_KEYLEN: res.byte_role = wbsv_pkg::ROLE_KEYLEN;
        wbsv_pkg::PH_KEY:    res.byte_role = wbsv_pkg::ROLE_KEY;
        wbsv_pkg::PH_VALLEN: res.byte_role = wbsv_pkg::ROLE_VALLEN;
        wbsv_pkg::PH_VAL:    res.byte_role = wbsv_pkg::ROLE_VAL;
        default:             res.byte_role = wbsv_pkg::ROLE_DISCARD;
      endcase
      if ((phase_r != wbsv_pkg::PH_HEADER) && (phase_r != wbsv_pkg::PH_TRAIL) &&
          (sticky_nxt != wbsv_pkg::ST_KIND)) begin
        res.entry_sequence = SEQ_W'(base_r) + SEQ_W'(idx_r);
        res.entry_kind     = kind_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.last_byte)) begin
      phase_r   <= wbsv_pkg::PH_HEADER;
      sticky_r  <= wbsv_pkg::ST_RUN;
      hdr_cnt_r <= '0;
      base_r    <= '0;
      base_hi_r <= 1'b0;
      total_r   <= '0;
      idx_r     <= '0;
      acc_r     <= '0;
      vcnt_r    <= '0;
      left_r    <= '0;
      kind_r    <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      sticky_r  <= sticky_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      base_r    <= base_nxt;
      base_hi_r <= base_hi_nxt;
      total_r   <= total_nxt;
      idx_r     <= idx_nxt;
      acc_r     <= acc_nxt;
      vcnt_r    <= vcnt_nxt;
      left_r    <= left_nxt;
      kind_r    <= kind_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/wbsv_out_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Write batch validator result stage
// Holds one result transaction until the downstream side takes it.
// ----------------------------------------------------------------------------
module wbsv_out_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire wbsv_pkg::res_t res_in,
  output logic                room,
  output logic                out_valid,
  input  wire logic           out_ready,
  output wbsv_pkg::res_t      res_q
);

  logic           vld_r;
  logic           vld_nxt;
  wbsv_pkg::res_t res_r;

  assign room    = !vld_r || out_ready;
  assign vld_nxt = push || (vld_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_r <= res_in;
    end
  end

  assign out_valid = vld_r;
  assign res_q     = res_r;

endmodule
`default_nettype wire

/* src/write_batch_stream_validator_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Write batch stream validator
// Walks an encoded write batch one byte per transaction and reports, for
// every byte, its role, the entry sequence and kind, record end and status.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                          | handshake
//  in_ch   | in  | data_byte[7:0], last_byte                        | valid/ready
//  out_ch  | out | byte_role[2:0], entry_sequence[55:0], entry_kind,| valid/ready
//          |     | entry_end, status[2:0], batch_done               |
//
//  One byte per clock while the result side does not stall; a result is
//  offered once its byte passes the input register and is parsed into the
//  result register. The parse-state register loop, updated once per byte,
//  sets the rate. rst_n is synchronous, active low; it empties both stages
//  and returns the parser to the header phase. The last byte of a batch also
//  re-arms it. A stalled result holds its stage; the input stage still takes
//  one more byte, and in_ch.ready drops only when both stages are full.
// ----------------------------------------------------------------------------
module write_batch_stream_validator_core #(
  parameter int SEQUENCE_BITS = wbsv_pkg::SEQ_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  wbsv_in_if.sink    in_ch,
  wbsv_out_if.source out_ch
);

  wbsv_pkg::item_t in_item;
  wbsv_pkg::item_t item;
  wbsv_pkg::res_t  res;
  wbsv_pkg::res_t  res_q;
  logic            item_vld;
  logic            room;
  logic            adv;
  logic            in_ready;
  logic            out_valid;

  assign in_item.data_byte = in_ch.data_byte;
  assign in_item.last_byte = in_ch.last_byte;

  // advance a byte through the parser whenever the result stage has space
  assign adv = item_vld && room;

  wbsv_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .pop      (adv),
    .item_vld (item_vld),
    .item     (item)
  );

  wbsv_parser #(
    .SEQUENCE_BITS (SEQUENCE_BITS)
  ) u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .item  (item),
    .res   (res)
  );

  wbsv_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (adv),
    .res_in    (res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .res_q     (res_q)
  );

  // drive the channel ports from the registered result
  assign in_ch.ready           = in_ready;
  assign out_ch.valid          = out_valid;
  assign out_ch.byte_role      = res_q.byte_role;
  assign out_ch.entry_sequence = res_q.entry_sequence;
  assign out_ch.entry_kind     = res_q.entry_kind;
  assign out_ch.entry_end      = res_q.entry_end;
  assign out_ch.status         = res_q.status;
  assign out_ch.batch_done     = res_q.batch_done;

endmodule
`default_nettype wire

/* src/wbsv_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Write batch validator checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module wbsv_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [2:0]                     byte_role,
  input wire logic [wbsv_pkg::SEQ_OUT_W-1:0] entry_sequence,
  input wire logic                           entry_kind,
  input wire logic                           entry_end,
  input wire logic [2:0]                     status,
  input wire logic                           batch_done
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(entry_sequence) &&
    $stable(status) && $stable(byte_role))
    else $error("result changed while stalled");

  // a closing transaction never reports running
  a_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && batch_done |-> status != wbsv_pkg::ST_RUN)
    else $error("batch closed with running status");

  // end-of-batch verdicts only on the last byte
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !batch_done |->
    status != wbsv_pkg::ST_OK && status != wbsv_pkg::ST_SHORT &&
    status != wbsv_pkg::ST_EXCESS)
    else $error("final verdict before last byte");

  // only a length or field byte closes a record
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && entry_end |->
    byte_role == wbsv_pkg::ROLE_KEYLEN || byte_role == wbsv_pkg::ROLE_KEY ||
    byte_role == wbsv_pkg::ROLE_VALLEN || byte_role == wbsv_pkg::ROLE_VAL)
    else $error("record end on wrong byte role");

  // discarded bytes carry no entry information
  a_discard: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && byte_role == wbsv_pkg::ROLE_DISCARD |->
    entry_sequence == '0 && !entry_kind && !entry_end)
    else $error("discarded byte carries entry data");

endmodule

bind write_batch_stream_validator_core wbsv_checker u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .byte_role      (out_ch.byte_role),
  .entry_sequence (out_ch.entry_sequence),
  .entry_kind     (out_ch.entry_kind),
  .entry_end      (out_ch.entry_end),
  .status         (out_ch.status),
  .batch_done     (out_ch.batch_done)
);
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Write batch stream validator testbench
// Walks a short table of hand-built batches, then random batches that are
// mostly well formed (with truncation, trailing bytes, excess counts, bad
// kinds, malformed lengths, range errors and plain noise mixed in). Every
// result transaction is checked field by field against a byte-level parser
// model, under four pacing phases and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;

  localparam int          SEQ_BITS        = wbsv_pkg::SEQ_BITS_DEF;
  localparam logic [63:0] SEQ_TOP         = (64'd1 << SEQ_BITS) - 64'd1;
  localparam int          RANDOM_BYTES    = 1700;
  localparam int          HOLD_OFF_CYCLES = 200;
  localparam int          WATCHDOG_LIMIT  = 3000;
  localparam int          DRAIN_CYCLES    = 10;
  localparam int          MAX_REPORTS     = 40;
  localparam logic [7:0]  KIND_DEL        = 8'd0;
  localparam logic [7:0]  KIND_PUT        = 8'd1;

  typedef struct {
    logic [7:0]     data;
    logic           last;
    bit             has_want;
    wbsv_pkg::res_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  wbsv_in_if  in_bus ();
  wbsv_out_if out_bus ();

  write_batch_stream_validator_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  // Free-running clock, 10 ns period
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Parser model state: mirrors the block's own parse registers
  // --------------------------------------------------------------------------
  wbsv_pkg::phase_t  prs_phase;
  logic [3:0]        prs_hdr_cnt;
  logic [63:0]       prs_base;
  logic [31:0]       prs_total;
  logic [31:0]       prs_index;
  logic [31:0]       prs_len_acc;
  logic [2:0]        prs_vcnt;
  logic [31:0]       prs_left;
  logic              prs_kind;
  wbsv_pkg::status_t prs_sticky;
  logic              prs_end;

  wbsv_pkg::res_t pending_results[$];
  stim_row_t      directed_rows[$];
  stim_row_t      cur_row;
  logic [7:0]     batch_bytes[$];

  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_req;
  int  mismatches;
  int  results_checked;
  int  bytes_accepted;
  int  batches_sent;
  int  quiet_cycles = 0;
  int  final_tally[8];

  // Return the parser to its post-reset state; also done by every last byte
  task automatic parser_clear();
    prs_phase   = wbsv_pkg::PH_HEADER;
    prs_hdr_cnt = '0;
    prs_base    = '0;
    prs_total   = '0;
    prs_index   = '0;
    prs_len_acc = '0;
    prs_vcnt    = '0;
    prs_left    = '0;
    prs_kind    = 1'b0;
    prs_sticky  = wbsv_pkg::ST_RUN;
  endtask

  task automatic close_record();
    prs_end   = 1'b1;
    prs_index = prs_index + 32'd1;
    prs_phase = (prs_index == prs_total) ? wbsv_pkg::PH_TRAIL : wbsv_pkg::PH_KIND;
  endtask

  // A finished key of a put record is followed by the value length
  task automatic close_field(input bit is_key);
    if (is_key && prs_kind) prs_phase = wbsv_pkg::PH_VALLEN;
    else close_record();
  endtask

  // Fold one varint32 byte into the length; payload bits past 32 are lost
  task automatic take_length(input logic [7:0] b, input bit is_key);
    logic [63:0] acc;
    acc = {32'd0, prs_len_acc} | (64'(b & wbsv_pkg::VARINT_MASK) << (7 * prs_vcnt));
    prs_len_acc = acc[31:0];
    if (b[wbsv_pkg::VARINT_CONT]) begin
      if (prs_vcnt >= wbsv_pkg::VARINT_LAST) prs_sticky = wbsv_pkg::ST_LEN;
      else prs_vcnt = prs_vcnt + 3'd1;
    end else begin
      prs_left    = prs_len_acc;
      prs_len_acc = '0;
      prs_vcnt    = '0;
      if (prs_left == 32'd0) close_field(is_key);
      else prs_phase = is_key ? wbsv_pkg::PH_KEY : wbsv_pkg::PH_VAL;
    end
  endtask

  function automatic bit seq_range_fits();
    if (prs_base > SEQ_TOP) return 1'b0;
    return (prs_total == 32'd0) || ({32'd0, prs_total - 32'd1} <= SEQ_TOP - prs_base);
  endfunction

  // Parse one batch byte and work out the result transaction it causes
  task automatic parse_batch_byte(input logic [7:0] b, input logic last,
                                  output wbsv_pkg::res_t r);
    bit                is_rec;
    bit                is_key;
    logic [3:0]        i;
    logic [63:0]       seq_sum;
    wbsv_pkg::status_t st;
    r           = '0;
    r.byte_role = wbsv_pkg::ROLE_DISCARD;
    prs_end     = 1'b0;
    is_rec      = 1'b0;
    if (prs_sticky == wbsv_pkg::ST_RUN) begin
      case (prs_phase)
        wbsv_pkg::PH_HEADER: begin
          i = prs_hdr_cnt;
          r.byte_role = wbsv_pkg::ROLE_HEADER;
          if (i < wbsv_pkg::BASE_BYTES) prs_base = prs_base | (64'(b) << (8 * i));
          else if (i <= wbsv_pkg::HDR_LAST_IDX)
            prs_total = prs_total | (32'(b) << (8 * (i - 8)));
          prs_hdr_cnt = i + 4'd1;
          if (prs_hdr_cnt == wbsv_pkg::HDR_LAST_IDX + 4'd1) begin
            if (!seq_range_fits()) prs_sticky = wbsv_pkg::ST_RANGE;
            else prs_phase = (prs_total == 32'd0) ? wbsv_pkg::PH_TRAIL : wbsv_pkg::PH_KIND;
          end
        end
        wbsv_pkg::PH_KIND: begin
          r.byte_role = wbsv_pkg::ROLE_KIND;
          is_rec = 1'b1;
          if (b > wbsv_pkg::KIND_MAX) begin
            prs_sticky = wbsv_pkg::ST_KIND;
          end else begin
            prs_kind    = b[0];
            prs_len_acc = '0;
            prs_vcnt    = '0;
            prs_phase   = wbsv_pkg::PH_KEYLEN;
          end
        end
        wbsv_pkg::PH_KEYLEN: begin
          r.byte_role = wbsv_pkg::ROLE_KEYLEN;
          is_rec = 1'b1;
          take_length(b, 1'b1);
        end
        wbsv_pkg::PH_VALLEN: begin
          r.byte_role = wbsv_pkg::ROLE_VALLEN;
          is_rec = 1'b1;
          take_length(b, 1'b0);
        end
        wbsv_pkg::PH_KEY, wbsv_pkg::PH_VAL: begin
          is_key = (prs_phase == wbsv_pkg::PH_KEY);
          r.byte_role = is_key ? wbsv_pkg::ROLE_KEY : wbsv_pkg::ROLE_VAL;
          is_rec = 1'b1;
          prs_left = prs_left - 32'd1;
          if (prs_left == 32'd0) close_field(is_key);
        end
        default: prs_sticky = wbsv_pkg::ST_TRAIL;
      endcase
      // A closing byte still belongs to the record it closed
      if (is_rec && prs_sticky != wbsv_pkg::ST_KIND) begin
        seq_sum = prs_base + {32'd0, prs_index - {31'd0, prs_end}};
        r.entry_sequence = seq_sum[wbsv_pkg::SEQ_OUT_W-1:0];
        r.entry_kind     = prs_kind;
      end
    end
    st = prs_sticky;
    if (last) begin
      if (st == wbsv_pkg::ST_RUN) begin
        case (prs_phase)
          wbsv_pkg::PH_HEADER: st = wbsv_pkg::ST_SHORT;
          wbsv_pkg::PH_KIND:   st = wbsv_pkg::ST_EXCESS;
          wbsv_pkg::PH_TRAIL:  st = wbsv_pkg::ST_OK;
          default:             st = wbsv_pkg::ST_LEN;
        endcase
      end
      parser_clear();
    end
    r.entry_end  = prs_end;
    r.status     = st;
    r.batch_done = last;
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] got_v,
                                 input logic [63:0] want_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] mismatch on result %0d, %s: got %0h, want %0h",
               $realtime, results_checked, field, got_v, want_v);
  endtask

  task automatic check_result(input wbsv_pkg::res_t got, input wbsv_pkg::res_t want);
    if (got.byte_role !== want.byte_role)
      report_mismatch("byte_role", got.byte_role, want.byte_role);
    if (got.entry_sequence !== want.entry_sequence)
      report_mismatch("entry_sequence", got.entry_sequence, want.entry_sequence);
    if (got.entry_kind !== want.entry_kind)
      report_mismatch("entry_kind", got.entry_kind, want.entry_kind);
    if (got.entry_end !== want.entry_end)
      report_mismatch("entry_end", got.entry_end, want.entry_end);
    if (got.status !== want.status)
      report_mismatch("status", got.status, want.status);
    if (got.batch_done !== want.batch_done)
      report_mismatch("batch_done", got.batch_done, want.batch_done);
  endtask

  // --------------------------------------------------------------------------
  // Scoreboard: sample both channels at the rising edge. Predict on every
  // accepted byte transaction; compare every accepted result transaction
  // with the oldest pending expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    wbsv_pkg::res_t want;
    wbsv_pkg::res_t got;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        parse_batch_byte(in_bus.data_byte, in_bus.last_byte, want);
        // Hand-typed rows override the model; the model still advances
        if (cur_row.has_want) want = cur_row.want;
        pending_results.insert(pending_results.size(), want);
        bytes_accepted++;
      end
      if (out_bus.valid && out_bus.ready) begin
        got.byte_role      = wbsv_pkg::role_t'(out_bus.byte_role);
        got.entry_sequence = out_bus.entry_sequence;
        got.entry_kind     = out_bus.entry_kind;
        got.entry_end      = out_bus.entry_end;
        got.status         = wbsv_pkg::status_t'(out_bus.status);
        got.batch_done     = out_bus.batch_done;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", got.byte_role, '0);
        end else begin
          want = pending_results.pop_front();
          check_result(got, want);
          if (want.batch_done) final_tally[want.status]++;
        end
        results_checked++;
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  always @(posedge clk) begin : watchdog
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no transaction for %0d cycles, %0d results pending",
               $realtime, quiet_cycles, pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Result sink: drive ready at the falling edge. A hold-off request pulls
  // ready low for a long counted stretch so that both stages fill up.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int hold_left;
    hold_left     = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one byte transaction, idling at random first; return at the
  // falling edge after it was accepted, with valid still high
  task automatic push_byte(input stim_row_t row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= row.data;
    in_bus.last_byte <= row.last;
    cur_row = row;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and hold the sender until every expected result is back
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic add_row(input logic [7:0] d, input logic l, input bit known,
                         input wbsv_pkg::role_t role, input wbsv_pkg::status_t st);
    stim_row_t row;
    row.data             = d;
    row.last             = l;
    row.has_want         = known;
    row.want             = '0;
    row.want.byte_role   = role;
    row.want.status      = st;
    row.want.batch_done  = l;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // --------------------------------------------------------------------------
  // Random batch construction
  // --------------------------------------------------------------------------
  task automatic append_byte(input logic [7:0] b);
    batch_bytes.insert(batch_bytes.size(), b);
  endtask

  task automatic emit_le(input logic [63:0] v, input int n);
    for (int k = 0; k < n; k++) append_byte(v[8*k +: 8]);
  endtask

  // Encode a length as varint32: minimal, padded, or five bytes whose
  // surplus high bits fall off the 32-bit length
  task automatic emit_length(input int unsigned len);
    int form;
    int pad;
    form = $urandom_range(9);
    if (len > 127) begin
      append_byte((8'(len) & wbsv_pkg::VARINT_MASK) | 8'h80);
      append_byte(8'(len >> 7));
    end else if (form < 6) begin
      append_byte(8'(len));
    end else if (form < 9) begin
      pad = $urandom_range(1, 3);
      append_byte(8'(len) | 8'h80);
      repeat (pad - 1) append_byte(8'h80);
      append_byte(8'h00);
    end else begin
      append_byte(8'(len) | 8'h80);
      repeat (3) append_byte(8'h80);
      append_byte({1'b0, 3'($urandom_range(7)), 4'h0});
    end
  endtask

  function automatic int unsigned field_len();
    if ($urandom_range(29) == 0) return $urandom_range(128, 135);
    return $urandom_range(0, 4);
  endfunction

  task automatic emit_record(input bit is_put);
    int unsigned flen;
    append_byte(is_put ? KIND_PUT : KIND_DEL);
    flen = field_len();
    emit_length(flen);
    repeat (flen) append_byte(8'($urandom));
    if (is_put) begin
      flen = field_len();
      emit_length(flen);
      repeat (flen) append_byte(8'($urandom));
    end
  endtask

  // Build one batch: mostly well formed, the rest broken in one way or noise
  task automatic build_batch();
    int          pick;
    int          nrec;
    int          cut;
    logic [63:0] base;
    logic [31:0] total;
    batch_bytes.delete();
    pick = $urandom_range(99);
    nrec = $urandom_range(0, 3);
    if (pick >= 93) begin
      repeat ($urandom_range(1, 24)) append_byte(8'($urandom));
      return;
    end
    case ($urandom_range(3))
      0, 1:    base = {32'd0, $urandom};
      2:       base = {8'd0, 24'($urandom), $urandom};
      default: base = SEQ_TOP - ((nrec == 0) ? 64'd0 : 64'(nrec - 1));
    endcase
    // Range error: either one past the top of the range, or high bits set
    if (pick >= 88) begin
      if ($urandom_range(1)) base = SEQ_TOP - 64'(nrec) + 64'd2;
      else base = {8'($urandom_range(1, 255)), 24'($urandom), $urandom};
    end
    total = 32'(nrec);
    if (pick >= 70 && pick < 76) begin
      total = ($urandom_range(4) == 0) ? 32'hFFFF_FFFF : 32'(nrec + $urandom_range(1, 3));
    end else if (pick >= 76 && pick < 88) begin
      total = 32'(nrec + 1);
    end
    emit_le(base, 8);
    emit_le({32'd0, total}, 4);
    repeat (nrec) emit_record($urandom_range(1));
    if (pick >= 55 && pick < 63) begin
      // Truncate anywhere, header included
      cut = $urandom_range(1, batch_bytes.size());
      while (batch_bytes.size() > cut) void'(batch_bytes.pop_back());
    end else if (pick >= 63 && pick < 70) begin
      repeat ($urandom_range(1, 3)) append_byte(8'($urandom));
    end else if (pick >= 76 && pick < 82) begin
      append_byte(8'($urandom_range(2, 255)));
      repeat ($urandom_range(0, 3)) append_byte(8'($urandom));
    end else if (pick >= 82 && pick < 88) begin
      // Five length bytes, all with the continuation bit set
      append_byte($urandom_range(1) ? KIND_PUT : KIND_DEL);
      repeat (5) append_byte(8'($urandom) | 8'h80);
      repeat ($urandom_range(0, 2)) append_byte(8'($urandom));
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus: reset, directed table, four paced random phases, drain
  // --------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t row;
    int        target;
    in_bus.valid     = 1'b0;
    in_bus.data_byte = 8'h00;
    in_bus.last_byte = 1'b0;
    rst_n            = 1'b0;
    hold_req         = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    mismatches       = 0;
    results_checked  = 0;
    bytes_accepted   = 0;
    batches_sent     = 0;
    cur_row          = '{default: '0};
    foreach (final_tally[k]) final_tally[k] = 0;
    parser_clear();

    // Directed table. Short header: a lone final byte
    add_row(8'hFF, 1'b1, 1'b1, wbsv_pkg::ROLE_HEADER, wbsv_pkg::ST_SHORT);
    // Base sequence all ones: out of range on the twelfth header byte
    for (int k = 0; k < 8; k++)
      add_row(8'hFF, 1'b0, 1'b1, wbsv_pkg::ROLE_HEADER, wbsv_pkg::ST_RUN);
    for (int k = 0; k < 3; k++)
      add_row(8'h00, 1'b0, 1'b1, wbsv_pkg::ROLE_HEADER, wbsv_pkg::ST_RUN);
    add_row(8'h00, 1'b1, 1'b1, wbsv_pkg::ROLE_HEADER, wbsv_pkg::ST_RANGE);
    // Base one below the top with two records just fits; then a bad kind
    // byte, and the last byte reports the held error
    add_row(8'hFE, 1'b0, 1'b1, wbsv_pkg::ROLE_HEADER, wbsv_pkg::ST_RUN);
    for (int k = 0; k < 6; k++)
      add_row(8'hFF, 1'b0, 1'b1, wbsv_pkg::ROLE_HEADER, wbsv_pkg::ST_RUN);
    add_row(8'h00, 1'b0, 1'b1, wbsv_pkg::ROLE_HEADER, wbsv_pkg::ST_RUN);
    add_row(8'h02, 1'b0, 1'b1, wbsv_pkg::ROLE_HEADER, wbsv_pkg::ST_RUN);
    for (int k = 0; k < 3; k++)
      add_row(8'h00, 1'b0, 1'b1, wbsv_pkg::ROLE_HEADER, wbsv_pkg::ST_RUN);
    add_row(8'h07, 1'b0, 1'b1, wbsv_pkg::ROLE_KIND, wbsv_pkg::ST_KIND);
    add_row(8'h00, 1'b1, 1'b1, wbsv_pkg::ROLE_DISCARD, wbsv_pkg::ST_KIND);

    // Hold reset, then release it at a falling edge
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[k]) begin
      push_byte(directed_rows[k]);
      if (directed_rows[k].last) batches_sent++;
    end
    wait_drained();

    // Random phases: no idling, sender idle, receiver stalling, both
    target = 0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      // Long receiver hold-off while the sender keeps offering bytes
      if (ph == 0) hold_req = 1'b1;
      target = target + RANDOM_BYTES / 4;
      while (bytes_accepted < target + directed_rows.size()) begin
        build_batch();
        foreach (batch_bytes[k]) begin
          row.data     = batch_bytes[k];
          row.last     = (k == batch_bytes.size() - 1);
          row.has_want = 1'b0;
          row.want     = '0;
          push_byte(row);
        end
        batches_sent++;
      end
      wait_drained();
    end

    // Let any stray late result show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d batches, %0d bytes, %0d results checked under four pacing phases",
             batches_sent, bytes_accepted, results_checked);
    $display("Final status: ok %0d, short %0d, range %0d, excess %0d, kind %0d, len %0d, trail %0d",
             final_tally[wbsv_pkg::ST_OK], final_tally[wbsv_pkg::ST_SHORT],
             final_tally[wbsv_pkg::ST_RANGE], final_tally[wbsv_pkg::ST_EXCESS],
             final_tally[wbsv_pkg::ST_KIND], final_tally[wbsv_pkg::ST_LEN],
             final_tally[wbsv_pkg::ST_TRAIL]);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
